### rtl/core/jws_pkg.sv
// Package for the Jaro-Winkler similarity block.
// Holds the command codes, the queued command type and the queue constants.
// No dependencies.
package jws_pkg;

   // Command codes carried in req_tuser; code 3 is unused and dropped
   typedef enum logic [1:0] {
      OP_APPEND_FIRST  = 2'd0,
      OP_APPEND_SECOND = 2'd1,
      OP_COMPARE       = 2'd2
   } op_type;

   // One classified command waiting for the engine
   typedef struct packed {
      op_type      op;
      logic [7:0]  ch;
   } cmd_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

   // Longest common prefix that earns the Winkler bonus
   localparam int PREFIX_MAX  = 4;
   localparam int PCT_FULL    = 100;

endpackage

### rtl/core/jws_front.sv
// Front end of the Jaro-Winkler block: accepts request transactions,
// drops unused codes and queues commands for the engine. Uses jws_pkg.
module jws_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] char_value
   input  logic [1:0]        req_tuser,   // [1:0] op
   output logic              q_valid,
   output jws_pkg::cmd_type  q_cmd,
   input  logic              q_pop
);

   jws_pkg::cmd_type              slot_ff [jws_pkg::QUEUE_DEPTH];
   logic [jws_pkg::QUEUE_PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [jws_pkg::QUEUE_PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [jws_pkg::QUEUE_PW:0]    count_ff, count_in;
   logic                          op_known;
   logic                          push;

   // Classify: only the three defined codes enter the queue
   always_comb begin
      unique case (req_tuser)
         jws_pkg::OP_APPEND_FIRST,
         jws_pkg::OP_APPEND_SECOND,
         jws_pkg::OP_COMPARE: op_known = 1'b1;
         default:             op_known = 1'b0;
      endcase
   end

   assign req_tready = (count_ff < (jws_pkg::QUEUE_PW+1)'(jws_pkg::QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && op_known;
   assign q_valid    = (count_ff != '0);
   assign q_cmd      = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage, payload only
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{op: jws_pkg::op_type'(req_tuser), ch: req_tdata};
      end
   end

endmodule

### rtl/core/jws_engine.sv
// Back end of the Jaro-Winkler block: string stores, match sequencer,
// shared multiplier, restoring divider and result register. Uses jws_pkg.
module jws_engine #(
   parameter int MAX_LEN = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  jws_pkg::cmd_type  q_cmd,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [6:0] similarity_pct, [7] zero
   output logic              rsp_tuser    // [0] truncated
);

   localparam int LW  = $clog2(MAX_LEN + 1);
   localparam int IW  = $clog2(MAX_LEN);
   localparam int OPW = 3 * LW + 3;
   localparam int AW  = 3 * LW + 14;

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_PRE_RD, S_PRE_CHK, S_WIN, S_MA_RD, S_MA_CAP,
      S_MB_RD, S_MB_CHK, S_TR_SCAN, S_TR_CHK, S_AR, S_DIV, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [7:0]         mem_a [MAX_LEN];
   logic [7:0]         mem_b [MAX_LEN];
   logic [7:0]         rd_a_ff, rd_b_ff;
   logic [IW-1:0]      rd_addr_a, rd_addr_b;
   logic               wr_a, wr_b;

   logic [LW-1:0]      len1_ff, len1_in, len2_ff, len2_in;
   logic               ovf_ff, ovf_in;
   logic               fm_ff [MAX_LEN];
   logic               fm_in [MAX_LEN];
   logic               sm_ff [MAX_LEN];
   logic               sm_in [MAX_LEN];

   logic [LW-1:0]      i_ff, i_in, j_ff, j_in, k_ff, k_in, hi_ff, hi_in;
   logic [LW-1:0]      m_ff, m_in, t_ff, t_in, win_ff, win_in;
   logic [2:0]         p_ff, p_in;
   logic               eq_ff, eq_in;
   logic [7:0]         ach_ff, ach_in;
   logic [2:0]         step_ff, step_in;
   logic [OPW-1:0]     t1_ff, t1_in, ll_ff, ll_in, n_ff, n_in, d_ff, d_in;
   logic [AW-1:0]      num_ff, num_in, dv_ff, dv_in;
   logic [2*OPW-1:0]   prod_ff;
   logic [OPW-1:0]     mul_x, mul_y;
   logic [7:0]         q_ff, q_in;
   logic [6:0]         res_ff, res_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [6:0]         rsp_pct_ff, rsp_pct_in;
   logic               rsp_trunc_ff, rsp_trunc_in;

   logic [LW-1:0]      min_len, max_len, half_len, lo_idx;
   logic [LW:0]        hi_sum;
   logic [AW-1:0]      trial;
   logic               chars_eq;

   assign min_len  = (len1_ff < len2_ff) ? len1_ff : len2_ff;
   assign max_len  = (len1_ff > len2_ff) ? len1_ff : len2_ff;
   assign half_len = max_len >> 1;
   assign lo_idx   = (i_ff > win_ff) ? (i_ff - win_ff) : '0;
   assign hi_sum   = (LW+1)'(i_ff) + (LW+1)'(win_ff) + (LW+1)'(1);
   assign chars_eq = (rd_a_ff == rd_b_ff);
   assign trial    = dv_ff << step_ff;

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      len1_in      = len1_ff;
      len2_in      = len2_ff;
      ovf_in       = ovf_ff;
      fm_in        = fm_ff;
      sm_in        = sm_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      hi_in        = hi_ff;
      m_in         = m_ff;
      t_in         = t_ff;
      win_in       = win_ff;
      p_in         = p_ff;
      eq_in        = eq_ff;
      ach_in       = ach_ff;
      step_in      = step_ff;
      t1_in        = t1_ff;
      ll_in        = ll_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      num_in       = num_ff;
      dv_in        = dv_ff;
      q_in         = q_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pct_in   = rsp_pct_ff;
      rsp_trunc_in = rsp_trunc_ff;
      q_pop        = 1'b0;
      wr_a         = 1'b0;
      wr_b         = 1'b0;
      rd_addr_a    = i_ff[IW-1:0];
      rd_addr_b    = i_ff[IW-1:0];
      mul_x        = '0;
      mul_y        = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.op)
                  jws_pkg::OP_APPEND_FIRST: begin
                     if (len1_ff < LW'(MAX_LEN)) begin
                        wr_a    = 1'b1;
                        len1_in = len1_ff + 1'b1;
                     end else begin
                        ovf_in  = 1'b1;
                     end
                  end
                  jws_pkg::OP_APPEND_SECOND: begin
                     if (len2_ff < LW'(MAX_LEN)) begin
                        wr_b    = 1'b1;
                        len2_in = len2_ff + 1'b1;
                     end else begin
                        ovf_in  = 1'b1;
                     end
                  end
                  default: state_in = S_START;
               endcase
            end
         end
         S_START: begin
            i_in  = '0;
            p_in  = '0;
            eq_in = 1'b1;
            if (len1_ff == '0 || len2_ff == '0) begin
               res_in   = '0;
               state_in = S_DONE;
            end else begin
               state_in = S_PRE_RD;
            end
         end
         // Prefix length and identity check, one position per pass through S_PRE_RD and S_PRE_CHK
         S_PRE_RD: begin
            state_in = S_PRE_CHK;
         end
         S_PRE_CHK: begin
            if (chars_eq) begin
               if (i_ff < LW'(jws_pkg::PREFIX_MAX) && LW'(p_ff) == i_ff) begin
                  p_in = p_ff + 1'b1;
               end
            end else begin
               eq_in = 1'b0;
            end
            i_in = i_ff + 1'b1;
            if (i_ff + 1'b1 == min_len) begin
               if (len1_ff == len2_ff && eq_ff && chars_eq) begin
                  res_in   = 7'(jws_pkg::PCT_FULL);
                  state_in = S_DONE;
               end else begin
                  state_in = S_WIN;
               end
            end else begin
               state_in = S_PRE_RD;
            end
         end
         S_WIN: begin
            win_in = (half_len == '0) ? '0 : half_len - 1'b1;
            for (int e = 0; e < MAX_LEN; e++) begin
               fm_in[e] = 1'b0;
               sm_in[e] = 1'b0;
            end
            i_in     = '0;
            m_in     = '0;
            state_in = S_MA_RD;
         end
         // Greedy matching inside the window
         S_MA_RD: begin
            if (i_ff == len1_ff) begin
               if (m_ff == '0) begin
                  res_in   = '0;
                  state_in = S_DONE;
               end else begin
                  i_in     = '0;
                  k_in     = '0;
                  t_in     = '0;
                  state_in = S_TR_SCAN;
               end
            end else begin
               j_in     = lo_idx;
               hi_in    = (hi_sum > (LW+1)'(len2_ff)) ? len2_ff : hi_sum[LW-1:0];
               state_in = S_MA_CAP;
            end
         end
         S_MA_CAP: begin
            ach_in = rd_a_ff;
            if (j_ff >= hi_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_MA_RD;
            end else begin
               state_in = S_MB_RD;
            end
         end
         S_MB_RD: begin
            rd_addr_b = j_ff[IW-1:0];
            state_in  = S_MB_CHK;
         end
         S_MB_CHK: begin
            if (!sm_ff[j_ff[IW-1:0]] && ach_ff == rd_b_ff) begin
               fm_in[i_ff[IW-1:0]] = 1'b1;
               sm_in[j_ff[IW-1:0]] = 1'b1;
               m_in     = m_ff + 1'b1;
               i_in     = i_ff + 1'b1;
               state_in = S_MA_RD;
            end else if ((LW+1)'(j_ff) + (LW+1)'(1) >= (LW+1)'(hi_ff)) begin
               i_in     = i_ff + 1'b1;
               state_in = S_MA_RD;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_MB_RD;
            end
         end
         // Half-transposition count over matched characters in order
         S_TR_SCAN: begin
            rd_addr_b = k_ff[IW-1:0];
            if (i_ff == len1_ff) begin
               step_in  = '0;
               state_in = S_AR;
            end else if (!fm_ff[i_ff[IW-1:0]]) begin
               i_in = i_ff + 1'b1;
            end else if (k_ff < len2_ff && !sm_ff[k_ff[IW-1:0]]) begin
               k_in = k_ff + 1'b1;
            end else if (k_ff >= len2_ff) begin
               step_in  = '0;
               state_in = S_AR;
            end else begin
               state_in = S_TR_CHK;
            end
         end
         S_TR_CHK: begin
            if (!chars_eq) begin
               t_in = t_ff + 1'b1;
            end
            k_in     = k_ff + 1'b1;
            i_in     = i_ff + 1'b1;
            state_in = S_TR_SCAN;
         end
         // Numerator and denominator through the shared multiplier
         S_AR: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               3'd0: begin
                  mul_x = OPW'(m_ff);
                  mul_y = OPW'(m_ff);
               end
               3'd1: begin
                  mul_x = prod_ff[OPW-1:0];
                  mul_y = OPW'(len1_ff) + OPW'(len2_ff);
               end
               3'd2: begin
                  t1_in = OPW'(prod_ff << 1);
                  mul_x = OPW'(len1_ff);
                  mul_y = OPW'(len2_ff);
               end
               3'd3: begin
                  ll_in = prod_ff[OPW-1:0];
                  mul_x = prod_ff[OPW-1:0];
                  mul_y = OPW'(({1'b0, m_ff} << 1) - (LW+1)'(t_ff));
               end
               3'd4: begin
                  n_in  = t1_ff + prod_ff[OPW-1:0];
                  mul_x = ll_ff;
                  mul_y = OPW'(m_ff);
               end
               3'd5: begin
                  d_in  = OPW'((prod_ff << 2) + (prod_ff << 1));
                  mul_x = n_ff;
                  mul_y = OPW'(1000);
               end
               3'd6: begin
                  num_in = prod_ff[AW-1:0] + (AW'(d_ff) << 2) + AW'(d_ff);
                  mul_x  = (d_ff > n_ff) ? (d_ff - n_ff) : '0;
                  mul_y  = OPW'(p_ff) * OPW'(jws_pkg::PCT_FULL);
               end
               default: begin
                  num_in   = num_ff + prod_ff[AW-1:0];
                  dv_in    = (AW'(d_ff) << 3) + (AW'(d_ff) << 1);
                  q_in     = '0;
                  step_in  = 3'd7;
                  state_in = S_DIV;
               end
            endcase
         end
         // Restoring division, one quotient bit per cycle
         S_DIV: begin
            if (num_ff >= trial) begin
               num_in         = num_ff - trial;
               q_in[step_ff]  = 1'b1;
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_pct_in   = res_ff;
               rsp_trunc_in = ovf_ff;
               len1_in      = '0;
               len2_in      = '0;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // Division result lands in the result register on its last bit
      if (state_ff == S_DIV && step_ff == '0) begin
         res_in = (q_in > 8'(jws_pkg::PCT_FULL)) ? 7'(jws_pkg::PCT_FULL) : q_in[6:0];
      end
      if (state_ff == S_TR_CHK || state_ff == S_PRE_RD) begin
         rd_addr_a = i_ff[IW-1:0];
      end
   end

   // Control state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len1_ff      <= '0;
         len2_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int e = 0; e < MAX_LEN; e++) begin
            fm_ff[e] <= 1'b0;
            sm_ff[e] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         len1_ff      <= len1_in;
         len2_ff      <= len2_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         fm_ff        <= fm_in;
         sm_ff        <= sm_in;
      end
   end

   // Working registers, no reset needed
   always_ff @(posedge clock) begin
      i_ff         <= i_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      hi_ff        <= hi_in;
      m_ff         <= m_in;
      t_ff         <= t_in;
      win_ff       <= win_in;
      p_ff         <= p_in;
      eq_ff        <= eq_in;
      ach_ff       <= ach_in;
      step_ff      <= step_in;
      t1_ff        <= t1_in;
      ll_ff        <= ll_in;
      n_ff         <= n_in;
      d_ff         <= d_in;
      num_ff       <= num_in;
      dv_ff        <= dv_in;
      q_ff         <= q_in;
      res_ff       <= res_in;
      rsp_pct_ff   <= rsp_pct_in;
      rsp_trunc_ff <= rsp_trunc_in;
      prod_ff      <= mul_x * mul_y;
   end

   // String stores, one write and one registered read each
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[len1_ff[IW-1:0]] <= q_cmd.ch;
      end
      rd_a_ff <= mem_a[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[len2_ff[IW-1:0]] <= q_cmd.ch;
      end
      rd_b_ff <= mem_b[rd_addr_b];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_pct_ff};
   assign rsp_tuser  = rsp_trunc_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len1_ff <= LW'(MAX_LEN) && len2_ff <= LW'(MAX_LEN))
      else $error("string length beyond store depth");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == S_IDLE)
      else $error("command taken while a compare is in progress");

   a_match_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TR_SCAN |-> m_ff <= len1_ff && m_ff <= len2_ff)
      else $error("match count exceeds a string length");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_pct_ff <= 7'(jws_pkg::PCT_FULL))
      else $error("similarity above full scale");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> $stable(rsp_pct_ff) && rsp_valid_ff)
      else $error("pending result overwritten");
`endif

endmodule

### rtl/core/jaro_winkler_similarity.sv
// Top level of the Jaro-Winkler similarity block.
// Instantiates jws_front (accept and queue) and jws_engine (compare); uses jws_pkg.
//
//  channel | direction | payload
//  req     | in        | tuser[1:0] op, tdata[7:0] char_value
//  rsp     | out       | tdata[6:0] similarity_pct, tuser[0] truncated
//
// Appends are stored in S_IDLE; the front queue accepts one per cycle unless full.
// A compare runs the prefix check, the window matching, the transposition count,
// 8 multiplier steps and 8 divider steps, exiting early on an empty, identical
// or unmatched pair; the string stores each have one read and the multiplier is shared.
// Reset clears lengths, flags, queue and the result valid at once.
// A waiting result does not stop appends; only the next compare stalls on it.
module jaro_winkler_similarity #(
   parameter int MAX_LEN = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_value
   input  logic [1:0]  req_tuser,   // [1:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] similarity_pct, [7] zero
   output logic        rsp_tuser    // [0] truncated
);

   logic              q_valid;
   logic              q_pop;
   jws_pkg::cmd_type  q_cmd;

   jws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   jws_engine #(
      .MAX_LEN (MAX_LEN)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### dv/tb_top.sv
// Self-checking testbench for jaro_winkler_similarity.
// Drives append and compare transactions, predicts each similarity result
// in exact integer arithmetic and checks it. Depends on jws_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int MAX_LEN   = 32;
   localparam int CYCLE_CAP = 2000000;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;

   typedef struct packed {
      logic [6:0] pct;
      logic       trunc;
   } score_type;

   // string state of the predictor
   logic [7:0] str_a [MAX_LEN];
   logic [7:0] str_b [MAX_LEN];
   int         len_a, len_b;
   bit         cut_seen;
   score_type  score_queue [$];

   int  mismatch_count = 0;
   int  result_count   = 0;
   int  item_count     = 0;
   int  cycle_count    = 0;
   int  send_idle_pct  = 0;
   int  recv_idle_pct  = 0;

   jaro_winkler_similarity #(.MAX_LEN(MAX_LEN)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   // Jaro-Winkler score of the loaded strings, rounded percent
   function automatic int jw_percent();
      bit          used_a [MAX_LEN];
      bit          used_b [MAX_LEN];
      int          win, lo, hi, m, t, k, p, pmax;
      bit          same;
      longint      n, d, num;
      if (len_a == 0 || len_b == 0) return 0;
      same = (len_a == len_b);
      for (int i = 0; i < len_a && same; i++) if (str_a[i] != str_b[i]) same = 0;
      if (same) return 100;
      win = (len_a > len_b ? len_a : len_b) / 2;
      win = win > 0 ? win - 1 : 0;
      m = 0; t = 0; k = 0; p = 0;
      for (int i = 0; i < MAX_LEN; i++) begin
         used_a[i] = 0; used_b[i] = 0;
      end
      for (int i = 0; i < len_a; i++) begin
         lo = i > win ? i - win : 0;
         hi = i + win + 1;
         if (hi > len_b) hi = len_b;
         for (int j = lo; j < hi; j++) begin
            if (!used_b[j] && str_a[i] == str_b[j]) begin
               used_a[i] = 1; used_b[j] = 1; m++;
               break;
            end
         end
      end
      if (m == 0) return 0;
      for (int i = 0; i < len_a; i++) begin
         if (!used_a[i]) continue;
         while (k < len_b && !used_b[k]) k++;
         if (k >= len_b) break;
         if (str_a[i] != str_b[k]) t++;
         k++;
      end
      pmax = len_a < len_b ? len_a : len_b;
      if (pmax > jws_pkg::PREFIX_MAX) pmax = jws_pkg::PREFIX_MAX;
      while (p < pmax && str_a[p] == str_b[p]) p++;
      n = 2 * longint'(m) * m * (len_a + len_b) + longint'(len_a) * len_b * (2 * m - t);
      d = 6 * longint'(m) * len_a * len_b;
      num = 1000 * n + 5 * d;
      if (d > n) num += 100 * longint'(p) * (d - n);
      num /= 10 * d;
      return num > jws_pkg::PCT_FULL ? jws_pkg::PCT_FULL : int'(num);
   endfunction

   // advance the predictor by one accepted transaction
   task automatic predict_item(logic [1:0] op, logic [7:0] ch);
      score_type s;
      case (op)
         jws_pkg::OP_APPEND_FIRST: begin
            if (len_a < MAX_LEN) str_a[len_a++] = ch;
            else cut_seen = 1;
         end
         jws_pkg::OP_APPEND_SECOND: begin
            if (len_b < MAX_LEN) str_b[len_b++] = ch;
            else cut_seen = 1;
         end
         jws_pkg::OP_COMPARE: begin
            s.pct = 7'(jw_percent());
            s.trunc = cut_seen;
            score_queue = {score_queue, s};
            len_a = 0; len_b = 0; cut_seen = 0;
         end
         default: ;
      endcase
   endtask

   // send one transaction, idling at random beforehand; valid stays high
   // after acceptance until the next transaction or an idle cycle
   task automatic send_item(logic [1:0] op, logic [7:0] ch);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(op, ch);
      item_count++;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
               what, got, want, result_count);
      mismatch_count++;
   endtask

   // receiver backpressure
   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // result checker
   always @(posedge clock) begin
      score_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (score_queue.size() == 0) begin
            report_mismatch("unexpected result pct", int'(rsp_tdata[6:0]), 0);
         end else begin
            want = score_queue.pop_front();
            if (rsp_tdata[6:0] !== want.pct) report_mismatch("pct", rsp_tdata[6:0], want.pct);
            if (rsp_tdata[7] !== 1'b0) report_mismatch("pad bit", rsp_tdata[7], 0);
            if (rsp_tuser !== want.trunc) report_mismatch("truncated", rsp_tuser, want.trunc);
         end
         result_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_CAP) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic load_pair(string a, string b);
      for (int i = 0; i < a.len(); i++) send_item(jws_pkg::OP_APPEND_FIRST, a[i]);
      for (int i = 0; i < b.len(); i++) send_item(jws_pkg::OP_APPEND_SECOND, b[i]);
      send_item(jws_pkg::OP_COMPARE, 8'($urandom_range(255)));
   endtask

   // drop valid and wait for every expected result
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (score_queue.size() != 0) @(posedge clock);
   endtask

   // directed: empty, identical, no match, classic pairs, extremes, unused code, overflow
   task automatic test_directed();
      load_pair("", "");
      load_pair("abc", "");
      load_pair("", "x");
      load_pair("MARTHA", "MARTHA");
      load_pair("abc", "xyz");
      load_pair("MARTHA", "MARHTA");
      load_pair("DIXON", "DICKSONX");
      send_item(jws_pkg::OP_APPEND_FIRST, 8'h00);
      send_item(jws_pkg::OP_APPEND_SECOND, 8'hFF);
      send_item(OP_UNUSED, 8'hA5);
      send_item(jws_pkg::OP_COMPARE, 8'h00);
      for (int i = 0; i < MAX_LEN + 2; i++) send_item(jws_pkg::OP_APPEND_FIRST, 8'(i));
      send_item(jws_pkg::OP_APPEND_SECOND, 8'd3);
      send_item(jws_pkg::OP_COMPARE, 8'hFF);
   endtask

   // random: mostly related string pairs, some noise and overflow
   task automatic test_random(int n_items);
      int  la, lb, start, mode;
      logic [7:0] base [MAX_LEN + 4];
      start = item_count;
      while (item_count - start < n_items) begin
         mode = $urandom_range(9);
         la = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN + 3) : $urandom_range(10);
         lb = ($urandom_range(9) == 0) ? $urandom_range(MAX_LEN + 3) : $urandom_range(10);
         for (int i = 0; i < MAX_LEN + 4; i++)
            base[i] = (mode < 7) ? 8'($urandom_range(3) + 8'h61) : 8'($urandom_range(255));
         for (int i = 0; i < la; i++) send_item(jws_pkg::OP_APPEND_FIRST, base[i]);
         for (int i = 0; i < lb; i++) begin
            if (mode < 4 && $urandom_range(3) == 0 && i + 1 < MAX_LEN + 4)
               send_item(jws_pkg::OP_APPEND_SECOND, base[i + 1]);
            else if (mode == 9)
               send_item(jws_pkg::OP_APPEND_SECOND, 8'($urandom_range(255)));
            else
               send_item(jws_pkg::OP_APPEND_SECOND, base[i]);
         end
         if ($urandom_range(7) == 0) send_item(OP_UNUSED, 8'($urandom_range(255)));
         send_item(jws_pkg::OP_COMPARE, 8'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 19; recv_idle_pct = 51;
      test_directed();
      test_random(200);
      // hold off until the block has drained
      wait_drained();
      send_idle_pct = 51; recv_idle_pct = 19;
      test_random(200);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(200);
      wait_drained();
      repeat (400) @(posedge clock);
      $display("Covered %0d transactions and %0d similarity results,", item_count, result_count);
      $display("including empty, identical, unmatched and truncated strings.");
      if (mismatch_count == 0 && score_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/jws_pkg.sv
rtl/core/jws_front.sv
rtl/core/jws_engine.sv
rtl/core/jaro_winkler_similarity.sv
dv/tb_top.sv
